/* design/ebz_pkg.sv */
package ebz_pkg;

	// Coefficient width; operands and the divisor are one bit narrower.
	localparam int unsigned DEF_OPERAND_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;        // capture both operands, set the rows to (a,1,0) and (b,0,1)
		logic div_init;    // clear remainder and products, load the dividend shifter
		logic div_step;    // one restoring-division bit plus product accumulation
		logic row_update;  // replace the first row and swap
		logic publish;     // copy the first row into the result registers
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic rb_zero;     // second remainder is zero
		logic div_last;    // the step in progress produces the last quotient bit
	} status_t;

endpackage

/* design/ebz_datapath.sv */
module ebz_datapath
	import ebz_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = DEF_OPERAND_WIDTH,
	localparam int unsigned OW = OPERAND_WIDTH - 1,
	localparam int unsigned CW = $clog2(OW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [OW-1:0]            in_first,
	input  logic [OW-1:0]            in_second,
	input  cmd_t                     cmd,
	output status_t                  status,
	output logic [OW-1:0]            res_divisor,
	output logic [OPERAND_WIDTH-1:0] res_coeff_first,
	output logic [OPERAND_WIDTH-1:0] res_coeff_second
);

	localparam logic [CW-1:0] CNT_LAST = CW'(OW - 1);

	logic [OW-1:0]            ra_q, rb_q, rem_q, dvd_q;
	logic [OPERAND_WIDTH-1:0] sa_q, sb_q, ta_q, tb_q, ps_q, pt_q;
	logic [CW-1:0]            cnt_q;
	logic [OW-1:0]            g_q;
	logic [OPERAND_WIDTH-1:0] cs_q, ct_q;

	logic [OW:0]              shifted;
	logic                     qbit;
	logic [OW:0]              diff;
	logic [OW-1:0]            rem_next;
	logic [OPERAND_WIDTH-1:0] ps_next, pt_next;

	// Restoring division: shift one dividend bit in, subtract when it fits.
	assign shifted  = {rem_q, dvd_q[OW-1]};
	assign qbit     = shifted >= {1'b0, rb_q};
	assign diff     = shifted - {1'b0, rb_q};
	assign rem_next = qbit ? diff[OW-1:0] : shifted[OW-1:0];

	// q*sb and q*tb built MSB first alongside the quotient bits, modulo 2^W.
	assign ps_next = {ps_q[OPERAND_WIDTH-2:0], 1'b0} + (qbit ? sb_q : '0);
	assign pt_next = {pt_q[OPERAND_WIDTH-2:0], 1'b0} + (qbit ? tb_q : '0);

	assign status.rb_zero  = (rb_q == '0);
	assign status.div_last = (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ra_q <= in_first;
			rb_q <= in_second;
			sa_q <= OPERAND_WIDTH'(1);
			sb_q <= '0;
			ta_q <= '0;
			tb_q <= OPERAND_WIDTH'(1);
		end else if (cmd.row_update) begin
			ra_q <= rb_q;
			rb_q <= rem_q;
			sa_q <= sb_q;
			sb_q <= sa_q - ps_q;
			ta_q <= tb_q;
			tb_q <= ta_q - pt_q;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= ra_q;
			ps_q  <= '0;
			pt_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[OW-2:0], 1'b0};
			ps_q  <= ps_next;
			pt_q  <= pt_next;
		end
		if (cmd.publish) begin
			g_q  <= ra_q;
			cs_q <= sa_q;
			ct_q <= ta_q;
		end
	end

	assign res_divisor      = g_q;
	assign res_coeff_first  = cs_q;
	assign res_coeff_second = ct_q;

	// The partial remainder stays below the divisor through every step.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < rb_q))
		else $error("partial remainder not below divisor");

endmodule

/* design/ebz_ctrl.sv */
module ebz_ctrl
	import ebz_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
			ST_CHECK:  state_next = status.rb_zero ? ST_FINISH : ST_DIV;
			ST_DIV:    if (status.div_last) state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_CHECK;
			ST_FINISH: if (out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_CHECK:  cmd.div_init   = !status.rb_zero;
			ST_DIV:    cmd.div_step   = 1'b1;
			ST_UPDATE: cmd.row_update = 1'b1;
			ST_FINISH: cmd.publish    = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_div_runs_to_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !status.div_last) |=> (state_q == ST_DIV))
		else $error("division left before its last step");

	a_update_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_update |-> ($past(state_q) == ST_DIV && $past(status.div_last)))
		else $error("row update without a finished division");

	a_publish_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> status.rb_zero)
		else $error("result published with non-zero remainder");

	a_publish_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

endmodule

/* design/extended_gcd_bezout_core.sv */
// Extended Euclidean GCD core. Each input transfer carries two non-negative
// integers a and b (OPERAND_WIDTH-1 bits each); each output transfer returns
// g = gcd(a, b) and two's-complement coefficients s and t (OPERAND_WIDTH bits)
// with a*s + b*t = g. With b = 0 the result is (a, 1, 0); with a = b = 0 it is
// (0, 1, 0). One item is in flight at a time. Each Euclid step runs a
// restoring division over one shared subtractor, one quotient bit per cycle,
// while q*s and q*t are accumulated by shift-and-add; a step is a
// remainder check, the division and a row update. The result sits in an
// output register, so the next input is taken as soon as the result is
// written, even while it still waits to be transferred. No state is kept
// between items.
module extended_gcd_bezout_core
	import ebz_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = DEF_OPERAND_WIDTH,
	localparam int unsigned OW    = OPERAND_WIDTH - 1,
	localparam int unsigned IN_W  = ((2 * OW + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((OW + 2 * OPERAND_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // first_operand, second_operand, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // divisor, coeff_first, coeff_second, zero pad
);

	cmd_t    cmd;
	status_t status;

	logic [OW-1:0]            first_operand, second_operand;
	logic [OW-1:0]            divisor;
	logic [OPERAND_WIDTH-1:0] coeff_first, coeff_second;

	// Unpack the operands; pad bits above them are ignored.
	assign first_operand  = s_tdata[OW-1:0];
	assign second_operand = s_tdata[2*OW-1:OW];

	// Sequencer: accept, check remainder, divide bit by bit, update rows, publish.
	ebz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Row registers, shared divider, product accumulators and result registers.
	ebz_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_first         (first_operand),
		.in_second        (second_operand),
		.cmd              (cmd),
		.status           (status),
		.res_divisor      (divisor),
		.res_coeff_first  (coeff_first),
		.res_coeff_second (coeff_second)
	);

	// Pack the result from the lowest bit up and zero-fill to whole bytes.
	assign m_tdata = OUT_W'({coeff_second, coeff_first, divisor});

endmodule
